// File: hdl/wheel_speed_pi_controller_core_defines.svh
// Assertion macros for the wheel speed PI controller core.
`ifndef WHEEL_SPEED_PI_CONTROLLER_CORE_DEFINES_SVH
`define WHEEL_SPEED_PI_CONTROLLER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define WSPC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define WSPC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/wspc_pkg.sv
// Package: types, constants and microcode program of the wheel speed PI core.
package wspc_pkg;

  localparam int Wheels = 4;

  // configuration port
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 24;
  localparam int GainW    = 24;
  localparam int PeriodW  = 16;
  localparam int RateW    = 20;
  localparam int CoefW    = 17;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PROP_GAIN     = 3'd0,
    REG_INTEGRAL_GAIN = 3'd1,
    REG_SAMPLE_PERIOD = 3'd2,
    REG_SAMPLE_RATE   = 3'd3,
    REG_COEF_MOVING   = 3'd4,
    REG_COEF_STILL    = 3'd5
  } cfg_reg_t;

  localparam logic [GainW-1:0]   PropGainRst     = 24'd0;
  localparam logic [GainW-1:0]   IntegralGainRst = 24'd0;
  localparam logic [PeriodW-1:0] SamplePeriodRst = 16'd66;
  localparam logic [RateW-1:0]   SampleRateRst   = 20'd1000;
  localparam logic [CoefW-1:0]   CoefMovingRst   = 17'd655;
  localparam logic [CoefW-1:0]   CoefStillRst    = 17'd4588;
  localparam logic [CoefW-1:0]   CoefOne         = 17'd65536;

  // payload words
  typedef struct packed {
    logic [1:0]         wheel;
    logic signed [31:0] tick_count;
    logic signed [23:0] target_rpm;
  } tick_t;

  typedef struct packed {
    logic [1:0]         wheel_out;
    logic signed [23:0] duty;
    logic signed [31:0] measured_rpm;
  } result_t;

  // datapath widths
  localparam int MulAW  = 33;
  localparam int MulBW  = 25;
  localparam int ProdW  = MulAW + MulBW;
  localparam int AccW   = ProdW + 1;
  localparam int FracW  = 16;
  localparam int RmagW  = AccW - FracW;
  localparam int RndBias = 32768;
  localparam int RawMax = 32767;
  localparam int RawMin = -32768;

  localparam logic signed [31:0] Int32Max = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Int32Min = 32'sh8000_0000;
  localparam logic signed [23:0] DutyMax  = 24'sd6553600;
  localparam logic signed [23:0] DutyMin  = -24'sd6553600;

  // divide by eleven, one byte a step
  localparam int DivDigits = 5;
  localparam int DigitW    = 8;
  localparam int DvdW      = DivDigits * DigitW;
  localparam int RemW      = 4;
  localparam int PartW     = RemW + DigitW;
  localparam int DivShift  = 20;
  localparam int QprodW    = PartW + CoefW;
  localparam int DigCntW   = 3;
  localparam logic [CoefW-1:0] DivRecip = 17'd95326;
  localparam logic [RemW-1:0]  Divisor  = 4'd11;
  localparam int RpmBias = 5;

  // control word
  typedef enum logic [2:0] {
    MUL_RATE, MUL_KEEP, MUL_NEW, MUL_TS, MUL_KP, MUL_KI
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD, ACC_LOAD, ACC_ADD
  } acc_op_t;

  typedef enum logic [3:0] {
    DST_NONE, DST_DIFF, DST_U, DST_Y, DST_DVD, DST_DIV,
    DST_RPM, DST_ERR, DST_INT, DST_DUTY
  } dst_t;

  typedef enum logic [1:0] {
    JMP_NEXT, JMP_LOOP, JMP_END
  } jmp_t;

  localparam int UcodeLen = 19;
  localparam int StepW    = 5;

  typedef struct packed {
    logic             mul_en;
    mul_sel_t         mul;
    acc_op_t          acc;
    logic             rnd;
    dst_t             dst;
    jmp_t             jmp;
    logic [StepW-1:0] jmp_to;
  } ctrl_t;

  localparam ctrl_t CtrlNop = '{
    mul_en: 1'b0, mul: MUL_RATE, acc: ACC_HOLD, rnd: 1'b0,
    dst: DST_NONE, jmp: JMP_NEXT, jmp_to: '0
  };

  // Program ROM, one control word per step.
  function automatic ctrl_t ucode(input logic [StepW-1:0] step);
    ctrl_t w;
    w = CtrlNop;
    unique case (step)
      5'd0:  w.dst = DST_DIFF;
      5'd1:  begin w.mul_en = 1'b1; w.mul = MUL_RATE; end
      5'd2:  begin w.dst = DST_U; w.mul_en = 1'b1; w.mul = MUL_KEEP; end
      5'd3:  begin w.mul_en = 1'b1; w.mul = MUL_NEW; w.acc = ACC_LOAD; end
      5'd4:  w.acc = ACC_ADD;
      5'd5:  w.rnd = 1'b1;
      5'd6:  w.dst = DST_Y;
      5'd7:  w.dst = DST_DVD;
      5'd8:  begin w.dst = DST_DIV; w.jmp = JMP_LOOP; w.jmp_to = 5'd8; end
      5'd9:  w.dst = DST_RPM;
      5'd10: w.dst = DST_ERR;
      5'd11: begin w.mul_en = 1'b1; w.mul = MUL_TS; end
      5'd12: begin w.acc = ACC_LOAD; w.mul_en = 1'b1; w.mul = MUL_KP; end
      5'd13: begin w.rnd = 1'b1; w.acc = ACC_LOAD; end
      5'd14: w.dst = DST_INT;
      5'd15: begin w.mul_en = 1'b1; w.mul = MUL_KI; end
      5'd16: w.acc = ACC_ADD;
      5'd17: w.rnd = 1'b1;
      5'd18: begin w.dst = DST_DUTY; w.jmp = JMP_END; end
      default: w = CtrlNop;
    endcase
    return w;
  endfunction

endpackage

// File: hdl/wheel_speed_pi_controller_core.sv
// Top level: microcoded PI speed controller shared by all wheels.
//
// Usage
//   tick channel   : one word per control tick for one wheel (wheel, cumulative
//                    encoder count, target rpm). Taken when tick_valid is high
//                    and tick_stall is low.
//   result channel : one word per tick of a wheel below WHEELS (duty, filtered
//                    rpm). Taken when result_valid is high and result_stall low.
//                    A tick for a wheel at or above WHEELS yields no word and
//                    leaves all state alone.
//   cfg port       : cfg_write/cfg_index/cfg_data, written while idle only.
// Timing
//   A 19-step program runs on one shared 33x25 multiplier; the divide by 11
//   for the rpm scale takes one byte per pass of its loop step, over the
//   five bytes of its dividend. No new tick is taken while the program runs;
//   the result word becomes valid as the core goes idle, and the next tick
//   can be taken from then on.
// Stalls
//   The result sits in an output register; the next tick is taken while it
//   waits. If it is still unclaimed when the next result is ready, the
//   program holds on its last step until the receiver takes it.
// Reset (rst, synchronous) restores register defaults and zeroes the count,
// filter and integrator state of every wheel at once.

`include "wheel_speed_pi_controller_core_defines.svh"

module wheel_speed_pi_controller_core #(
  parameter int WHEELS = wspc_pkg::Wheels
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          tick_valid,
  output logic                          tick_stall,
  input  wspc_pkg::tick_t               tick,
  output logic                          result_valid,
  input  logic                          result_stall,
  output wspc_pkg::result_t             result,
  input  logic                          cfg_write,
  input  logic [wspc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [wspc_pkg::CfgDataW-1:0] cfg_data
);

  localparam int IdxW = (WHEELS > 1) ? $clog2(WHEELS) : 1;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [wspc_pkg::GainW-1:0]   prop_gain;
  logic [wspc_pkg::GainW-1:0]   integral_gain;
  logic [wspc_pkg::PeriodW-1:0] sample_period;
  logic [wspc_pkg::RateW-1:0]   sample_rate;
  logic [wspc_pkg::CoefW-1:0]   filter_coef_moving;
  logic [wspc_pkg::CoefW-1:0]   filter_coef_still;

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain          <= wspc_pkg::PropGainRst;
      integral_gain      <= wspc_pkg::IntegralGainRst;
      sample_period      <= wspc_pkg::SamplePeriodRst;
      sample_rate        <= wspc_pkg::SampleRateRst;
      filter_coef_moving <= wspc_pkg::CoefMovingRst;
      filter_coef_still  <= wspc_pkg::CoefStillRst;
    end else if (cfg_write) begin
      unique case (wspc_pkg::cfg_reg_t'(cfg_index))
        wspc_pkg::REG_PROP_GAIN:     prop_gain     <= cfg_data[wspc_pkg::GainW-1:0];
        wspc_pkg::REG_INTEGRAL_GAIN: integral_gain <= cfg_data[wspc_pkg::GainW-1:0];
        wspc_pkg::REG_SAMPLE_PERIOD: sample_period <= cfg_data[wspc_pkg::PeriodW-1:0];
        wspc_pkg::REG_SAMPLE_RATE:   sample_rate   <= cfg_data[wspc_pkg::RateW-1:0];
        wspc_pkg::REG_COEF_MOVING:   filter_coef_moving <= cfg_data[wspc_pkg::CoefW-1:0];
        wspc_pkg::REG_COEF_STILL:    filter_coef_still  <= cfg_data[wspc_pkg::CoefW-1:0];
        default: ; // unused indexes are dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: step counter, program ROM, hold on a full output register
  // ---------------------------------------------------------------------------
  logic                          busy;
  logic [wspc_pkg::StepW-1:0]    step;
  wspc_pkg::ctrl_t               word;
  logic                          accept;
  logic                          start;
  logic                          hold;
  logic                          adv;
  logic [wspc_pkg::DigCntW-1:0]  dig;
  logic                          last_digit;

  assign word       = wspc_pkg::ucode(step);
  assign tick_stall = busy;
  assign accept     = tick_valid && !busy;
  assign start      = accept && (32'(tick.wheel) < WHEELS);
  assign hold       = busy && (word.dst == wspc_pkg::DST_DUTY) && result_valid && result_stall;
  assign adv        = busy && !hold;
  assign last_digit = (dig == wspc_pkg::DigCntW'(wspc_pkg::DivDigits - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (adv) begin
      unique case (word.jmp)
        wspc_pkg::JMP_NEXT: step <= step + 1'b1;
        wspc_pkg::JMP_LOOP: begin
          if (last_digit) begin
            step <= step + 1'b1;
          end else begin
            step <= word.jmp_to;
          end
        end
        wspc_pkg::JMP_END: busy <= 1'b0;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Latched tick word
  // ---------------------------------------------------------------------------
  logic [1:0]         wheel_sel;
  logic [31:0]        count_in;
  logic signed [23:0] target_in;
  logic [IdxW+1:0]    wheel_ext;
  logic [IdxW-1:0]    widx;

  always_ff @(posedge clk) begin
    if (accept) begin
      wheel_sel <= tick.wheel;
      count_in  <= tick.tick_count;
      target_in <= tick.target_rpm;
    end
  end

  assign wheel_ext = {{IdxW{1'b0}}, wheel_sel};
  assign widx      = wheel_ext[IdxW-1:0];

  // ---------------------------------------------------------------------------
  // Per-wheel state, cleared by reset
  // ---------------------------------------------------------------------------
  logic [31:0]        last_count     [WHEELS];
  logic signed [31:0] filtered_rate  [WHEELS];
  logic signed [31:0] error_integral [WHEELS];

  // ---------------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------------
  logic signed [31:0]                  diff;
  logic [wspc_pkg::CoefW-1:0]          coef;
  logic [wspc_pkg::CoefW-1:0]          keep;
  logic signed [31:0]                  rate_q;
  logic signed [wspc_pkg::ProdW-1:0]   prod;
  logic signed [wspc_pkg::AccW-1:0]    acc;
  logic [wspc_pkg::RmagW-1:0]          rmag;
  logic                                rneg;
  logic [31:0]                         ymag;
  logic                                yneg;
  logic [wspc_pkg::DvdW-1:0]           dvd;
  logic [wspc_pkg::DvdW-1:0]           quo;
  logic [wspc_pkg::RemW-1:0]           rem;
  logic signed [31:0]                  rpm;
  logic signed [32:0]                  err;
  logic signed [31:0]                  integ;

  // filter coefficient: moving one for a positive count, capped at one
  logic                       moving;
  logic [wspc_pkg::CoefW-1:0] coef_sel;
  logic [wspc_pkg::CoefW-1:0] coef_lim;

  assign moving   = !count_in[31] && (count_in != '0);
  assign coef_sel = moving ? filter_coef_moving : filter_coef_still;
  assign coef_lim = (coef_sel > wspc_pkg::CoefOne) ? wspc_pkg::CoefOne : coef_sel;

  // shared multiplier operands
  logic signed [wspc_pkg::MulAW-1:0] mul_a;
  logic signed [wspc_pkg::MulBW-1:0] mul_b;
  logic signed [31:0]                f_cur;
  logic signed [31:0]                i_cur;

  assign f_cur = filtered_rate[widx];
  assign i_cur = error_integral[widx];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (word.mul)
      wspc_pkg::MUL_RATE: begin mul_a = {diff[31], diff};     mul_b = {5'b0, sample_rate};   end
      wspc_pkg::MUL_KEEP: begin mul_a = {f_cur[31], f_cur};   mul_b = {8'b0, keep};          end
      wspc_pkg::MUL_NEW:  begin mul_a = {rate_q[31], rate_q}; mul_b = {8'b0, coef};          end
      wspc_pkg::MUL_TS:   begin mul_a = err;                  mul_b = {9'b0, sample_period}; end
      wspc_pkg::MUL_KP:   begin mul_a = err;                  mul_b = {1'b0, prop_gain};     end
      wspc_pkg::MUL_KI:   begin mul_a = {integ[31], integ};   mul_b = {1'b0, integral_gain}; end
      default: ;
    endcase
  end

  // round-to-nearest magnitude of acc / 2^16 (ties away from zero), one adder
  logic [wspc_pkg::AccW-1:0] acc_u;
  logic [wspc_pkg::AccW-1:0] rsum;

  assign acc_u = acc;
  assign rsum  = acc[wspc_pkg::AccW-1]
               ? (~acc_u + wspc_pkg::AccW'(wspc_pkg::RndBias + 1))
               : (acc_u + wspc_pkg::AccW'(wspc_pkg::RndBias));

  // divide-by-11 digit step via reciprocal multiply
  logic [wspc_pkg::PartW-1:0]  part;
  logic [wspc_pkg::QprodW-1:0] qprod;
  logic [wspc_pkg::DigitW-1:0] qd;
  logic [wspc_pkg::PartW-1:0]  rem_full;

  assign part     = {rem, dvd[wspc_pkg::DvdW-1 -: wspc_pkg::DigitW]};
  assign qprod    = wspc_pkg::QprodW'(part) * wspc_pkg::QprodW'(wspc_pkg::DivRecip);
  assign qd       = qprod[wspc_pkg::DivShift +: wspc_pkg::DigitW];
  assign rem_full = part - (wspc_pkg::PartW'(qd) * wspc_pkg::PartW'(wspc_pkg::Divisor));

  // saturating integrator update
  logic signed [34:0] int_delta;
  logic signed [34:0] int_sum;
  logic signed [31:0] int_sat;

  assign int_delta = {2'b00, rmag[32:0]};
  assign int_sum   = rneg ? (35'(i_cur) - int_delta) : (35'(i_cur) + int_delta);
  assign int_sat   = (int_sum > 35'(wspc_pkg::Int32Max)) ? wspc_pkg::Int32Max
                   : (int_sum < 35'(wspc_pkg::Int32Min)) ? wspc_pkg::Int32Min
                   : int_sum[31:0];

  // duty clamp
  logic [23:0]        duty_mag;
  logic signed [23:0] duty_val;

  assign duty_mag = (rmag > wspc_pkg::RmagW'(wspc_pkg::DutyMax)) ? wspc_pkg::DutyMax
                  : rmag[23:0];
  assign duty_val = rneg ? -duty_mag : duty_mag;

  // state arrays
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WHEELS; i++) begin
        last_count[i]     <= '0;
        filtered_rate[i]  <= '0;
        error_integral[i] <= '0;
      end
    end else if (adv) begin
      if (word.dst == wspc_pkg::DST_DIFF) begin
        last_count[widx] <= count_in;
      end
      if (word.dst == wspc_pkg::DST_Y) begin
        filtered_rate[widx] <= rneg ? -rmag[31:0] : rmag[31:0];
      end
      if (word.dst == wspc_pkg::DST_INT) begin
        error_integral[widx] <= int_sat;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (adv) begin
      if (word.mul_en) begin
        prod <= mul_a * mul_b;
      end
      case (word.acc)
        wspc_pkg::ACC_LOAD: acc <= wspc_pkg::AccW'(prod);
        wspc_pkg::ACC_ADD:  acc <= acc + wspc_pkg::AccW'(prod);
        default: ;
      endcase
      if (word.rnd) begin
        rmag <= rsum[wspc_pkg::AccW-1:wspc_pkg::FracW];
        rneg <= acc[wspc_pkg::AccW-1];
      end
      case (word.dst)
        wspc_pkg::DST_DIFF: begin
          diff <= count_in - last_count[widx];
          coef <= coef_lim;
          keep <= wspc_pkg::CoefOne - coef_lim;
        end
        wspc_pkg::DST_U: begin
          if (prod > wspc_pkg::ProdW'(wspc_pkg::RawMax)) begin
            rate_q <= wspc_pkg::Int32Max;
          end else if (prod < wspc_pkg::ProdW'(wspc_pkg::RawMin)) begin
            rate_q <= wspc_pkg::Int32Min;
          end else begin
            rate_q <= {prod[15:0], 16'h0000};
          end
        end
        wspc_pkg::DST_Y: begin
          ymag <= rmag[31:0];
          yneg <= rneg;
        end
        wspc_pkg::DST_DVD: begin
          // |y| * 30 + 5, ready for the divide by 11
          dvd <= (wspc_pkg::DvdW'(ymag) << 5) - (wspc_pkg::DvdW'(ymag) << 1)
               + wspc_pkg::DvdW'(wspc_pkg::RpmBias);
          rem <= '0;
          dig <= '0;
        end
        wspc_pkg::DST_DIV: begin
          dvd <= dvd << wspc_pkg::DigitW;
          quo <= {quo[wspc_pkg::DvdW-wspc_pkg::DigitW-1:0], qd};
          rem <= rem_full[wspc_pkg::RemW-1:0];
          dig <= dig + 1'b1;
        end
        wspc_pkg::DST_RPM: begin
          if (!yneg) begin
            rpm <= (quo > wspc_pkg::DvdW'(wspc_pkg::Int32Max)) ? wspc_pkg::Int32Max
                 : quo[31:0];
          end else begin
            rpm <= (quo > wspc_pkg::DvdW'(32'h8000_0000)) ? wspc_pkg::Int32Min
                 : -quo[31:0];
          end
        end
        wspc_pkg::DST_ERR: err <= (33'(target_in) <<< 8) - 33'(rpm);
        wspc_pkg::DST_INT: integ <= int_sat;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv && (word.dst == wspc_pkg::DST_DUTY)) begin
      result_valid <= 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && (word.dst == wspc_pkg::DST_DUTY)) begin
      result.wheel_out    <= wheel_sel;
      result.duty         <= duty_val;
      result.measured_rpm <= rpm;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `WSPC_ASSERT_IMP(a_step_range, busy, step < wspc_pkg::StepW'(wspc_pkg::UcodeLen), "step beyond program")
  `WSPC_ASSERT_IMP(a_rem_range, busy && (word.dst == wspc_pkg::DST_DIV), rem < wspc_pkg::Divisor, "divider remainder not below 11")
  `WSPC_ASSERT_IMP(a_duty_range, result_valid, (result.duty >= wspc_pkg::DutyMin) && (result.duty <= wspc_pkg::DutyMax), "duty outside limit")
  `WSPC_ASSERT_NXT(a_done, adv && (word.jmp == wspc_pkg::JMP_END), result_valid && !busy, "finished word not presented")

endmodule

// File: bench/pi_result_check.sv
// Result checker for the wheel speed PI core: predicts every result word and compares it.
`timescale 1ns / 1ps

module pi_result_check
  import wspc_pkg::*;
#(
  parameter int WHEELS = Wheels
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                tick_valid,
  input  logic                tick_stall,
  input  tick_t               tick,
  input  logic                result_valid,
  input  logic                result_stall,
  input  result_t             result,
  input  logic                cfg_write,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  output int unsigned         failures,
  output int unsigned         pending
);

  localparam longint Unity  = 65536;
  localparam longint S32Max = Int32Max;
  localparam longint S32Min = Int32Min;
  localparam longint DutyHi = DutyMax;
  localparam longint DutyLo = DutyMin;

  // register copies
  logic [GainW-1:0]   kp;
  logic [GainW-1:0]   ki;
  logic [PeriodW-1:0] ts;
  logic [RateW-1:0]   rate;
  logic [CoefW-1:0]   coef_moving;
  logic [CoefW-1:0]   coef_still;

  // per-wheel state
  logic [31:0]        prev_count [WHEELS];
  logic signed [31:0] rate_lp    [WHEELS];
  logic signed [31:0] err_sum    [WHEELS];

  result_t due_results [$];
  result_t want;

  // nearest, ties away from zero
  function automatic longint round_div(input longint num, input longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // One control tick: rate, filter, rpm, integrator, duty. Updates the wheel's state.
  function automatic result_t control_step(input tick_t t);
    logic [1:0]  w;
    logic [31:0] moved;
    longint      delta, raw, drive, coef, y, rpm, err, integ, duty;
    result_t     r;
    w = t.wheel;
    moved = t.tick_count - prev_count[w];
    delta = longint'($signed(moved));
    prev_count[w] = t.tick_count;

    raw = delta * longint'(rate);
    if (raw > RawMax)
      drive = S32Max;
    else if (raw < RawMin)
      drive = S32Min;
    else
      drive = raw * Unity;

    coef = (t.tick_count > 0) ? longint'(coef_moving) : longint'(coef_still);
    if (coef > Unity)
      coef = Unity;
    y = round_div((Unity - coef) * longint'(rate_lp[w]) + coef * drive, Unity);
    y = clamp(y, S32Min, S32Max);
    rate_lp[w] = y[31:0];

    rpm = clamp(round_div(y * 30, 11), S32Min, S32Max);
    err = longint'(t.target_rpm) * 256 - rpm;
    integ = longint'(err_sum[w]) + round_div(err * longint'(ts), Unity);
    integ = clamp(integ, S32Min, S32Max);
    err_sum[w] = integ[31:0];

    duty = round_div(longint'(kp) * err + longint'(ki) * integ, Unity);
    duty = clamp(duty, DutyLo, DutyHi);

    r.wheel_out    = w;
    r.duty         = duty[23:0];
    r.measured_rpm = rpm[31:0];
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      kp          = PropGainRst;
      ki          = IntegralGainRst;
      ts          = SamplePeriodRst;
      rate        = SampleRateRst;
      coef_moving = CoefMovingRst;
      coef_still  = CoefStillRst;
      for (int i = 0; i < WHEELS; i++) begin
        prev_count[i] = '0;
        rate_lp[i]    = '0;
        err_sum[i]    = '0;
      end
      due_results.delete();
      failures = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_PROP_GAIN:     kp          = cfg_data[GainW-1:0];
          REG_INTEGRAL_GAIN: ki          = cfg_data[GainW-1:0];
          REG_SAMPLE_PERIOD: ts          = cfg_data[PeriodW-1:0];
          REG_SAMPLE_RATE:   rate        = cfg_data[RateW-1:0];
          REG_COEF_MOVING:   coef_moving = cfg_data[CoefW-1:0];
          REG_COEF_STILL:    coef_still  = cfg_data[CoefW-1:0];
          default: ;
        endcase
      end
      // compare before queuing, so a word can never match its own tick
      if (result_valid && !result_stall) begin
        if (due_results.size() == 0) begin
          $error("result word for wheel %0d with none due", result.wheel_out);
          failures++;
        end else begin
          want = due_results.pop_front();
          if (result.wheel_out !== want.wheel_out) begin
            $error("wheel_out: expected %0d, got %0d", want.wheel_out, result.wheel_out);
            failures++;
          end
          if (result.duty !== want.duty) begin
            $error("duty: expected %0d, got %0d", want.duty, result.duty);
            failures++;
          end
          if (result.measured_rpm !== want.measured_rpm) begin
            $error("measured_rpm: expected %0d, got %0d",
                   want.measured_rpm, result.measured_rpm);
            failures++;
          end
        end
      end
      // wheels beyond the count give no word and touch no state
      if (tick_valid && !tick_stall && tick.wheel < WHEELS)
        due_results.push_back(control_step(tick));
    end
    pending = due_results.size();
  end

endmodule

// File: bench/testbench.sv
// Testbench top: tick stimulus, register settings, result back-pressure and the verdict.
`timescale 1ns / 1ps

// Plan of the run
//   A short directed part first: register reset values, every wheel, count and
//   target extremes, rate saturation both ways, the wrap of the count difference,
//   filter coefficients above one, zero rate and zero period, writes to the two
//   spare register indexes, and duty clamping at both limits.
//   Then eight random phases, each under its own register settings (extremes in
//   some). Most ticks follow a plausible encoder: each wheel's count walks by a
//   few steps per tick; the rest are large jumps and wholly random counts.
// Handshakes
//   Inputs change on the falling edge; words are taken on the rising edge.
//   Sender and receiver each draw a random wait of up to MaxWait per word, except in phases
//   where either side runs flat out. One phase asks the receiver for a long
//   hold-off while the sender keeps offering ticks, so the core backs up and
//   stalls its input. Before each set of register writes the sender stops and
//   waits until every due word has come back, so the core is idle.
// The checker beside the core predicts and compares; this module drives and gives the verdict.

module testbench;
  import wspc_pkg::*;

  localparam int CycleLimit = 400000;  // run limit for the watchdog
  localparam int HoldCycles = 400;     // long receiver hold-off
  localparam int TailCycles = 48;      // quiet time after the last word
  localparam int Phases     = 8;
  localparam int PhaseTicks = 128;
  localparam int MaxWait    = 11;

  // indexes past the last register: writes must be ignored
  localparam logic [CfgIdxW-1:0] RegSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSpareHi = 3'd7;

  logic                clk;
  logic                rst;
  logic                tick_valid;
  logic                tick_stall;
  tick_t               tick;
  logic                result_valid;
  logic                result_stall;
  result_t             result;
  logic                cfg_write;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  int unsigned failures;
  int unsigned pending;
  int unsigned cycles;

  bit          tx_steady;    // sender offers back to back
  bit          rx_steady;    // receiver never stalls
  int unsigned hold_asked;   // bumped by the stimulus to ask for a long hold-off

  logic signed [31:0] enc_count [Wheels];  // cumulative count each wheel is at

  wheel_speed_pi_controller_core dut (
    .clk          (clk),
    .rst          (rst),
    .tick_valid   (tick_valid),
    .tick_stall   (tick_stall),
    .tick         (tick),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  pi_result_check #(
    .WHEELS (Wheels)
  ) result_check (
    .clk          (clk),
    .rst          (rst),
    .tick_valid   (tick_valid),
    .tick_stall   (tick_stall),
    .tick         (tick),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .failures     (failures),
    .pending      (pending)
  );

  // 12 ns period
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // watchdog: a hung handshake ends here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver. The stall for each word is drawn before the word shows up, so
  // waits land on every phase of the core's program. A pending hold-off request
  // replaces one draw with a long stretch, counted here.
  initial begin : receiver
    int unsigned hold_done;
    int unsigned wait_n;
    hold_done = 0;
    result_stall = 1'b0;
    forever begin
      if (hold_asked != hold_done) begin
        wait_n = HoldCycles;
        hold_done++;
      end else begin
        wait_n = rx_steady ? 0 : $urandom_range(0, MaxWait);
      end
      @(negedge clk);
      if (wait_n > 0) begin
        result_stall <= 1'b1;
        repeat (wait_n) @(negedge clk);
      end
      result_stall <= 1'b0;
      do @(posedge clk); while (!result_valid);
    end
  end

  // Offer one tick word; returns at the edge that takes it. Valid stays high
  // afterwards so back-to-back words never drop it within a step.
  task automatic send_tick(input logic [1:0] w, input logic signed [31:0] cnt,
                           input logic signed [23:0] aim);
    int unsigned gap;
    gap = tx_steady ? 0 : $urandom_range(0, MaxWait);
    @(negedge clk);
    if (gap > 0) begin
      tick_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    tick_valid <= 1'b1;
    tick <= '{wheel: w, tick_count: cnt, target_rpm: aim};
    do @(posedge clk); while (tick_stall);
  endtask

  // Stop offering and wait for every due word: the core is idle afterwards.
  task automatic settle();
    @(negedge clk);
    tick_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic load_settings(input logic [GainW-1:0] p_gain, input logic [GainW-1:0] i_gain,
                               input logic [PeriodW-1:0] period, input logic [RateW-1:0] hz,
                               input logic [CoefW-1:0] c_move, input logic [CoefW-1:0] c_still);
    write_reg(REG_PROP_GAIN, CfgDataW'(p_gain));
    write_reg(REG_INTEGRAL_GAIN, CfgDataW'(i_gain));
    write_reg(REG_SAMPLE_PERIOD, CfgDataW'(period));
    write_reg(REG_SAMPLE_RATE, CfgDataW'(hz));
    write_reg(REG_COEF_MOVING, CfgDataW'(c_move));
    write_reg(REG_COEF_STILL, CfgDataW'(c_still));
  endtask

  initial begin : stimulus
    int               step;
    int unsigned      pick;
    logic [1:0]       w;
    logic signed [23:0] aim;

    rst        = 1'b1;
    tick_valid = 1'b0;
    tick       = '0;
    cfg_write  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    tx_steady  = 1'b0;
    rx_steady  = 1'b0;
    for (int i = 0; i < Wheels; i++)
      enc_count[i] = '0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset values: zero gains give zero duty, rpm shows rate and filter defaults
    send_tick(2'd0, 32'sd10, 24'sd25600);
    send_tick(2'd3, -32'sd7, 24'sd0);

    // unity kp, modest ki, nominal timing
    settle();
    load_settings(24'd65536, 24'd8192, 16'd66, 20'd1000, 17'd655, 17'd4588);
    send_tick(2'd1, 32'sd0, 24'sd0);                          // zero count: still filter
    send_tick(2'd2, 32'sd25, 24'sd51200);                     // rear left, own encoder
    send_tick(2'd3, 32'sd25, 24'sd51200);                     // rear right
    send_tick(2'd0, 32'sd35, 24'sh7FFFFF);                    // highest target
    send_tick(2'd1, -32'sd40, 24'sh800000);                   // lowest target
    send_tick(2'd2, 32'sh7FFF_FFFF, 24'sd0);                  // rate saturates high
    send_tick(2'd2, 32'sh8000_0000, 24'sd0);                  // difference wraps to +1
    send_tick(2'd3, 32'sh8000_0000, 24'sd0);                  // difference wraps: rate saturates high
    send_tick(2'd0, -32'sd1, -24'sd1);
    send_tick(2'd1, 32'sh7FFF_FFFF, 24'sh7FFFFF);

    // full gains, longest period, fastest rate, coefficients above one
    settle();
    load_settings(24'hFF_FFFF, 24'hFF_FFFF, 16'hFFFF, 20'hF_FFFF, 17'h1_FFFF, 17'd65537);
    write_reg(RegSpareLo, 24'hFF_FFFF);
    write_reg(RegSpareHi, 24'h5A_5A5A);
    send_tick(2'd0, 32'sd100, 24'sh7FFFFF);                   // duty clamps high
    send_tick(2'd0, 32'sd50, 24'sh800000);                    // duty clamps low
    send_tick(2'd1, -32'sd5, 24'sd0);
    send_tick(2'd2, 32'sh0001_0000, 24'sh123456);
    send_tick(2'd3, 32'sd0, 24'sd0);

    // zero rate, zero period: no rate, integrator frozen
    settle();
    load_settings(24'd1, 24'd0, 16'd0, 20'd0, 17'd0, 17'd65536);
    send_tick(2'd0, 32'sd1000, 24'sd76800);
    send_tick(2'd1, -32'sd1000, -24'sd76800);
    send_tick(2'd2, 32'sd7, 24'sd1);
    send_tick(2'd3, 32'sh5555_5555, 24'shAAAAAA);

    for (int p = 0; p < Phases; p++) begin
      settle();
      case (p)
        0: load_settings(GainW'($urandom_range(0, 262144)), GainW'($urandom_range(0, 65536)),
                         PeriodW'($urandom_range(66, 1000)), 20'd1000, 17'd655, 17'd4588);
        1: load_settings(GainW'($urandom_range(0, 131072)), GainW'($urandom_range(0, 131072)),
                         PeriodW'($urandom_range(1, 65535)), RateW'($urandom_range(1, 4000)),
                         CoefW'($urandom_range(0, 65536)), CoefW'($urandom_range(0, 65536)));
        2: load_settings(24'hFF_FFFF, 24'd0, 16'd1, 20'd1, 17'd65536, 17'd0);
        3: load_settings(24'd0, 24'hFF_FFFF, 16'hFFFF, 20'hF_FFFF, 17'd0, 17'h1_FFFF);
        default: load_settings(GainW'($urandom), GainW'($urandom), PeriodW'($urandom),
                               RateW'($urandom), CoefW'($urandom), CoefW'($urandom));
      endcase
      tx_steady = p[0] || (p == 2);
      rx_steady = p[1];
      // long receiver hold-off while the sender keeps going: the core backs up
      if (p == 2)
        hold_asked++;

      for (int i = 0; i < PhaseTicks; i++) begin
        w = 2'($urandom_range(0, Wheels - 1));
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          step = int'($urandom_range(0, 60)) - 30;
          enc_count[w] = enc_count[w] + step;
        end else if (pick < 90) begin
          step = int'($urandom_range(0, 2000000)) - 1000000;
          enc_count[w] = enc_count[w] + step;
        end else begin
          enc_count[w] = $urandom;
        end
        if ($urandom_range(0, 4) != 0)
          aim = 24'(int'($urandom_range(0, 256000)) - 128000);
        else
          aim = 24'($urandom);
        send_tick(w, enc_count[w], aim);
      end
    end

    settle();
    repeat (TailCycles) @(negedge clk);
    if (failures == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
